[design/lz77_greedy_compressor_core_defines.svh]
// ----------------------------------------------------------------------------
// lz77_greedy_compressor_core_defines
// Assertion macros shared by the compressor RTL.
// ----------------------------------------------------------------------------
`ifndef LZ77_GREEDY_COMPRESSOR_CORE_DEFINES_SVH
`define LZ77_GREEDY_COMPRESSOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define LZGC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define LZGC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LZGC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LZGC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[design/lzgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzgc_pkg
// Shared constants and token type for the greedy LZ77 compressor.
// ----------------------------------------------------------------------------
package lzgc_pkg;

    localparam int DEF_WINDOW    = 4096;
    localparam int DEF_LOOKAHEAD = 16;
    localparam int MIN_MATCH     = 3;

    // One output token
    typedef struct packed {
        logic        stream_done;
        logic        run_last;
        logic [7:0]  literal_byte;
        logic [7:0]  match_length;
        logic [15:0] match_offset;
        logic        is_match;
    } token_t;

endpackage

[design/lz77_greedy_compressor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_greedy_compressor_core
// Greedy LZ77 tokenizer over a sliding history window.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one uncompressed byte per item (s_tdata), s_tlast
//   marks the last byte of a stream. Master channel gives tokens: literal or
//   (offset, length) match. m_tlast marks the last token an input item caused,
//   m_tuser[1] the final token of the stream.
//   A non-last item that leaves fewer than LOOKAHEAD bytes pending gives no
//   token and leaves the core in S_IDLE, so such items can follow back to
//   back. Otherwise each token runs a byte-serial search with one shared
//   compare unit on a two-read history memory: for each candidate offset,
//   up to WINDOW of them, S_RD and S_CMP alternate per compared byte and
//   S_EVAL ends the candidate; S_HEAD and S_LATCH come before and S_DECIDE
//   after. The registered reads and the one comparator set the search pace.
//   s_tready is low for the whole search. A stalled master holds the finished
//   token in the output register; the next token waits for it to drain.
//   Reset (aresetn low, synchronous) clears state, head and the pending and
//   coded counts; history needs no clearing since only this stream is read.
// ----------------------------------------------------------------------------
`include "lz77_greedy_compressor_core_defines.svh"

module lz77_greedy_compressor_core #(
    parameter int WINDOW    = lzgc_pkg::DEF_WINDOW,
    parameter int LOOKAHEAD = lzgc_pkg::DEF_LOOKAHEAD
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] match_offset, [23:16] match_length,
                                   // [31:24] literal_byte
    output logic        m_tlast,   // run_last
    output logic [1:0]  m_tuser    // [0] is_match, [1] stream_done
);

    import lzgc_pkg::*;

    localparam int BUF = WINDOW + LOOKAHEAD;
    localparam int AW  = $clog2(BUF);
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int PW  = $clog2(LOOKAHEAD + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_HEAD, S_LATCH, S_RD, S_CMP, S_EVAL, S_DECIDE
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [PW-1:0] pend_reg, pend_next;
    logic [CW-1:0] coded_reg, coded_next;
    logic          last_reg, last_next;
    logic [CW-1:0] d_reg, d_next;
    logic [AW-1:0] cand_reg, cand_next;
    logic [AW-1:0] pa_reg, pa_next;
    logic [AW-1:0] pb_reg, pb_next;
    logic [PW-1:0] k_reg, k_next;
    logic [PW-1:0] best_reg, best_next;
    logic [CW-1:0] off_reg, off_next;
    logic [7:0]    lit_reg, lit_next;
    logic          mvalid_reg, mvalid_next;
    token_t        tok_reg, tok_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_a, rd_b;

    logic [AW:0]   wsum, hsum, csub;
    logic [PW-1:0] tok_len, pend_after;
    logic [CW:0]   coded_sum;
    logic          out_free, more;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(BUF - 1)) ? '0 : p + AW'(1);
    endfunction

    lzgc_hist_mem #(.DEPTH(BUF), .AW(AW)) u_hist (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (s_tdata),
        .rd_addr_a (pa_reg),
        .rd_addr_b (pb_reg),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // write position for incoming byte
    assign wsum    = {1'b0, head_reg} + (AW+1)'(pend_reg);
    assign wr_addr = (wsum >= (AW+1)'(BUF)) ? AW'(wsum - (AW+1)'(BUF)) : AW'(wsum);
    assign wr_en   = (state_reg == S_IDLE) && s_tvalid;

    // oldest candidate start: head - coded, ring wrap
    assign csub = ({1'b0, head_reg} >= (AW+1)'(coded_reg))
                ? {1'b0, head_reg} - (AW+1)'(coded_reg)
                : {1'b0, head_reg} + (AW+1)'(BUF) - (AW+1)'(coded_reg);

    // token commit values
    assign tok_len    = (best_reg >= PW'(MIN_MATCH)) ? best_reg : PW'(1);
    assign pend_after = pend_reg - tok_len;
    assign hsum       = {1'b0, head_reg} + (AW+1)'(tok_len);
    assign coded_sum  = {1'b0, coded_reg} + (CW+1)'(tok_len);
    assign out_free   = !mvalid_reg || m_tready;
    assign more       = last_reg && (pend_after != '0);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        pend_next   = pend_reg;
        coded_next  = coded_reg;
        last_next   = last_reg;
        d_next      = d_reg;
        cand_next   = cand_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        k_next      = k_reg;
        best_next   = best_reg;
        off_next    = off_reg;
        lit_next    = lit_reg;
        mvalid_next = mvalid_reg && !m_tready;
        tok_next    = tok_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    pend_next = pend_reg + PW'(1);
                    last_next = s_tlast;
                    pb_next   = head_reg;
                    if (s_tlast || (pend_reg + PW'(1) == PW'(LOOKAHEAD))) begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                state_next = S_LATCH;
            end
            S_LATCH: begin
                lit_next  = rd_b;
                best_next = '0;
                off_next  = '0;
                if (coded_reg == '0) begin
                    state_next = S_DECIDE;
                end else begin
                    d_next     = coded_reg;
                    cand_next  = AW'(csub);
                    pa_next    = AW'(csub);
                    pb_next    = head_reg;
                    k_next     = '0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = (k_reg == pend_reg) ? S_EVAL : S_CMP;
            end
            S_CMP: begin
                if (rd_a == rd_b) begin
                    k_next     = k_reg + PW'(1);
                    pa_next    = ring_inc(pa_reg);
                    pb_next    = ring_inc(pb_reg);
                    state_next = S_RD;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (k_reg > best_reg) begin
                    best_next = k_reg;
                    off_next  = d_reg;
                end
                if ((k_reg == PW'(LOOKAHEAD)) || (d_reg == CW'(1))) begin
                    state_next = S_DECIDE;
                end else begin
                    d_next     = d_reg - CW'(1);
                    cand_next  = ring_inc(cand_reg);
                    pa_next    = ring_inc(cand_reg);
                    pb_next    = head_reg;
                    k_next     = '0;
                    state_next = S_RD;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    if (best_reg >= PW'(MIN_MATCH)) begin
                        tok_next.is_match     = 1'b1;
                        tok_next.match_offset = 16'(off_reg);
                        tok_next.match_length = 8'(best_reg);
                        tok_next.literal_byte = '0;
                    end else begin
                        tok_next.is_match     = 1'b0;
                        tok_next.match_offset = '0;
                        tok_next.match_length = '0;
                        tok_next.literal_byte = lit_reg;
                    end
                    tok_next.run_last    = !more;
                    tok_next.stream_done = last_reg && (pend_after == '0);
                    pend_next  = pend_after;
                    head_next  = (hsum >= (AW+1)'(BUF)) ? AW'(hsum - (AW+1)'(BUF))
                                                        : AW'(hsum);
                    coded_next = (coded_sum > (CW+1)'(WINDOW)) ? CW'(WINDOW)
                                                               : CW'(coded_sum);
                    if (more) begin
                        pb_next    = (hsum >= (AW+1)'(BUF)) ? AW'(hsum - (AW+1)'(BUF))
                                                            : AW'(hsum);
                        state_next = S_HEAD;
                    end else begin
                        state_next = S_IDLE;
                        if (last_reg) begin
                            head_next  = '0;
                            pend_next  = '0;
                            coded_next = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            pend_reg   <= '0;
            coded_reg  <= '0;
            last_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            pend_reg   <= pend_next;
            coded_reg  <= coded_next;
            last_reg   <= last_next;
            mvalid_reg <= mvalid_next;
        end
        d_reg    <= d_next;
        cand_reg <= cand_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        k_reg    <= k_next;
        best_reg <= best_next;
        off_reg  <= off_next;
        lit_reg  <= lit_next;
        tok_reg  <= tok_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {tok_reg.literal_byte, tok_reg.match_length, tok_reg.match_offset};
    assign m_tlast  = tok_reg.run_last;
    assign m_tuser  = {tok_reg.stream_done, tok_reg.is_match};

    // checks
    `LZGC_ASSERT_IMP(a_pend_bound, aclk, aresetn, 1'b1, pend_reg <= PW'(LOOKAHEAD),
        "pending count above lookahead")
    `LZGC_ASSERT_IMP(a_k_bound, aclk, aresetn, state_reg == S_CMP, k_reg < pend_reg,
        "match length ran past pending bytes")
    `LZGC_ASSERT_IMP(a_done_last, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast,
        "stream end token not marked last")
    `LZGC_ASSERT_NXT(a_stream_clear, aclk, aresetn,
        (state_reg == S_DECIDE) && out_free && last_reg && (pend_after == '0),
        (pend_reg == '0) && (coded_reg == '0) && (head_reg == '0),
        "stream end did not clear pointers")

endmodule

[design/lzgc_hist_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzgc_hist_mem
// History ring memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lzgc_hist_mem #(
    parameter int DEPTH = 4112,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [7:0]    rd_data_a,
    output logic [7:0]    rd_data_b
);

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two read ports, registered
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
